FILE: rtl/core/bounded_positional_list_top_macros.svh
// Assertion macros shared by the list controller and datapath.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef BOUNDED_POSITIONAL_LIST_TOP_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever ant holds, con holds too.
`define BLP_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);
// Next-cycle implication: whenever ant holds, con holds in the next cycle.
`define BLP_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);
`else
`define BLP_ASSERT_SAME(lbl, ant, con, msg)
`define BLP_ASSERT_NEXT(lbl, ant, con, msg)
`endif
`endif

FILE: rtl/core/blp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface structs
// for the bounded positional list. No dependencies.
package blp_pkg;

  localparam int CAPACITY    = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 4;
  localparam int STAT_W      = 2;
  localparam int ELEM_W      = 32;
  localparam int LEN_W       = 5;
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_DEL_AT     = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADIDX = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;   // take the input transaction and execute its op
    logic rd_next;  // emit the next readout element
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic slot_free;   // output register empty or being taken this cycle
    logic read_burst;  // input op is a readout of more than one element
    logic rd_last;     // readout index points at the final element
  } sts_t;

endpackage

FILE: rtl/core/blp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the bounded positional list.
// Depends on blp_pkg and bounded_positional_list_top_macros.svh.
`include "bounded_positional_list_top_macros.svh"
module blp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  blp_pkg::sts_t sts,
  output blp_pkg::cmd_t cmd
);

  blp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      blp_pkg::S_IDLE: begin
        if (in_tvalid && sts.slot_free && sts.read_burst) begin
          state_nxt = blp_pkg::S_READ;
        end
      end
      blp_pkg::S_READ: begin
        if (sts.slot_free && sts.rd_last) begin
          state_nxt = blp_pkg::S_IDLE;
        end
      end
      default: state_nxt = blp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.rd_next = 1'b0;
    unique case (state_r)
      blp_pkg::S_IDLE: begin
        in_tready  = sts.slot_free;
        cmd.accept = in_tvalid && sts.slot_free;
      end
      blp_pkg::S_READ: begin
        cmd.rd_next = sts.slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  `BLP_ASSERT_SAME(a_no_input_in_read, state_r == blp_pkg::S_READ, !in_tready, "input taken during readout")
  `BLP_ASSERT_NEXT(a_read_ends, (state_r == blp_pkg::S_READ) && cmd.rd_next && sts.rd_last, state_r == blp_pkg::S_IDLE, "readout did not end after last element")

endmodule

FILE: rtl/core/blp_dp.sv
`timescale 1ns / 1ps
// Datapath for the bounded positional list: cell row, count, readout
// index and output register. Depends on blp_pkg and the macros header.
`include "bounded_positional_list_top_macros.svh"
module blp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [blp_pkg::OP_W-1:0]     in_op,
  input  logic [blp_pkg::VALUE_W-1:0]  in_value,
  input  logic [blp_pkg::POS_W-1:0]    in_position,
  input  blp_pkg::cmd_t                cmd,
  output blp_pkg::sts_t                sts,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [blp_pkg::STAT_W-1:0]   out_status,
  output logic [blp_pkg::ELEM_W-1:0]   out_element,
  output logic [blp_pkg::LEN_W-1:0]    out_length,
  output logic                         out_last
);

  logic [blp_pkg::DATA_WIDTH-1:0] cell_r   [blp_pkg::CAPACITY];
  logic [blp_pkg::DATA_WIDTH-1:0] cell_nxt [blp_pkg::CAPACITY];
  logic [blp_pkg::DATA_WIDTH-1:0] up_shift [blp_pkg::CAPACITY];
  logic [blp_pkg::DATA_WIDTH-1:0] dn_shift [blp_pkg::CAPACITY];
  logic [blp_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [blp_pkg::IDX_W-1:0]      idx_r, idx_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [blp_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [blp_pkg::ELEM_W-1:0]     out_elem_r, out_elem_nxt;
  logic [blp_pkg::LEN_W-1:0]      out_len_r, out_len_nxt;
  logic                           out_last_r, out_last_nxt;

  blp_pkg::op_t                   op;
  blp_pkg::status_t               status_c;
  logic                           ins_c, del_c;
  logic [blp_pkg::IDX_W-1:0]      at_c;
  logic [blp_pkg::ELEM_W-1:0]     elem_c;
  logic                           last_c;
  logic [blp_pkg::CMP_W-1:0]      pos_w, cnt_w;
  logic                           full_c, empty_c, pos_bad_c;
  logic [blp_pkg::DATA_WIDTH-1:0] new_word;

  assign op        = blp_pkg::op_t'(in_op);
  assign pos_w     = blp_pkg::CMP_W'(in_position);
  assign cnt_w     = blp_pkg::CMP_W'(count_r);
  assign full_c    = cnt_w >= blp_pkg::CMP_W'(blp_pkg::CAPACITY);
  assign empty_c   = count_r == '0;
  assign pos_bad_c = pos_w >= cnt_w;
  assign new_word  = blp_pkg::DATA_WIDTH'($signed(in_value));

  // Decode op against the current count.
  always_comb begin
    status_c = blp_pkg::STAT_OK;
    ins_c    = 1'b0;
    del_c    = 1'b0;
    at_c     = '0;
    elem_c   = '0;
    last_c   = 1'b1;
    unique case (op)
      blp_pkg::OP_PUSH_FRONT: begin
        if (full_c) status_c = blp_pkg::STAT_FULL;
        else ins_c = 1'b1;
      end
      blp_pkg::OP_PUSH_BACK: begin
        if (full_c) begin
          status_c = blp_pkg::STAT_FULL;
        end else begin
          ins_c = 1'b1;
          at_c  = blp_pkg::IDX_W'(count_r);
        end
      end
      blp_pkg::OP_INS_AFTER: begin
        if (full_c) begin
          status_c = blp_pkg::STAT_FULL;
        end else if (pos_bad_c) begin
          status_c = blp_pkg::STAT_BADIDX;
        end else begin
          ins_c = 1'b1;
          at_c  = blp_pkg::IDX_W'(pos_w + blp_pkg::CMP_W'(1));
        end
      end
      blp_pkg::OP_POP_FRONT: begin
        if (empty_c) status_c = blp_pkg::STAT_EMPTY;
        else del_c = 1'b1;
      end
      blp_pkg::OP_POP_BACK: begin
        if (empty_c) begin
          status_c = blp_pkg::STAT_EMPTY;
        end else begin
          del_c = 1'b1;
          at_c  = blp_pkg::IDX_W'(count_r - blp_pkg::CNT_W'(1));
        end
      end
      blp_pkg::OP_DEL_AT: begin
        if (empty_c) begin
          status_c = blp_pkg::STAT_EMPTY;
        end else if (pos_bad_c) begin
          status_c = blp_pkg::STAT_BADIDX;
        end else begin
          del_c = 1'b1;
          at_c  = blp_pkg::IDX_W'(pos_w);
        end
      end
      blp_pkg::OP_READ: begin
        if (empty_c) begin
          status_c = blp_pkg::STAT_EMPTY;
        end else begin
          elem_c = blp_pkg::ELEM_W'($signed(cell_r[0]));
          last_c = count_r == blp_pkg::CNT_W'(1);
        end
      end
      default: status_c = blp_pkg::STAT_BADIDX;
    endcase
  end

  // Neighbor taps for the parallel shift.
  always_comb begin
    up_shift[0] = cell_r[0];
    for (int i = 1; i < blp_pkg::CAPACITY; i++) begin
      up_shift[i] = cell_r[i-1];
    end
    dn_shift[blp_pkg::CAPACITY-1] = cell_r[blp_pkg::CAPACITY-1];
    for (int i = 0; i < blp_pkg::CAPACITY - 1; i++) begin
      dn_shift[i] = cell_r[i+1];
    end
  end

  // Open or close a gap at at_c: cells below it hold, cells above shift.
  always_comb begin
    for (int i = 0; i < blp_pkg::CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.accept && ins_c) begin
        if (blp_pkg::IDX_W'(i) == at_c) cell_nxt[i] = new_word;
        else if (blp_pkg::IDX_W'(i) > at_c) cell_nxt[i] = up_shift[i];
      end else if (cmd.accept && del_c) begin
        if (blp_pkg::IDX_W'(i) >= at_c) cell_nxt[i] = dn_shift[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.accept && ins_c) count_nxt = count_r + blp_pkg::CNT_W'(1);
    else if (cmd.accept && del_c) count_nxt = count_r - blp_pkg::CNT_W'(1);
  end

  assign sts.slot_free  = !out_valid_r || out_tready;
  assign sts.read_burst = (op == blp_pkg::OP_READ) && (count_r > blp_pkg::CNT_W'(1));
  assign sts.rd_last    = (blp_pkg::CNT_W'(idx_r) + blp_pkg::CNT_W'(1)) == count_r;

  // Readout index and output register.
  always_comb begin
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    if (cmd.accept) begin
      idx_nxt        = blp_pkg::IDX_W'(1);
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_c;
      out_elem_nxt   = elem_c;
      out_len_nxt    = blp_pkg::LEN_W'(count_nxt);
      out_last_nxt   = last_c;
    end else if (cmd.rd_next) begin
      idx_nxt        = idx_r + blp_pkg::IDX_W'(1);
      out_valid_nxt  = 1'b1;
      out_status_nxt = blp_pkg::STAT_OK;
      out_elem_nxt   = blp_pkg::ELEM_W'($signed(cell_r[idx_r]));
      out_len_nxt    = blp_pkg::LEN_W'(count_r);
      out_last_nxt   = sts.rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < blp_pkg::CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_elem_r;
  assign out_length  = out_len_r;
  assign out_last    = out_last_r;

  `BLP_ASSERT_SAME(a_count_bounded, 1'b1, count_r <= blp_pkg::CNT_W'(blp_pkg::CAPACITY), "element count above capacity")
  `BLP_ASSERT_NEXT(a_count_holds, !cmd.accept, $stable(count_r), "count changed without an accepted op")

endmodule

FILE: rtl/core/bounded_positional_list_top.sv
`timescale 1ns / 1ps
// Top level of the bounded positional list: stream ports, controller
// and datapath. Depends on blp_pkg, blp_ctrl and blp_dp.
//
//   channel   dir   tuser     tdata                       end mark
//   in_*      in    op        value, position             -
//   out_*     out   status    element, length             out_tlast
//
// Insert, delete and invalid ops give one result transaction; the input is
// ready again as soon as the output register is free. Readout gives one
// result per element, one per cycle while the sink takes them, and holds
// off the input until the last element has been issued; the result channel
// carries one element per transaction.
// Back-pressure on out_* stalls the controller and holds the output register.
// rst_n clears the count and the state machine; cell contents are left as
// they are.
module bounded_positional_list_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] op
  input  logic [blp_pkg::OP_W-1:0]          in_tuser,
  // [31:0] value, [35:32] position, [39:36] zero pad
  input  logic [blp_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status
  output logic [blp_pkg::STAT_W-1:0]        out_tuser,
  // [31:0] element, [36:32] length, [39:37] zero pad
  output logic [blp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);

  localparam int POS_LO = blp_pkg::VALUE_W;
  localparam int LEN_LO = blp_pkg::ELEM_W;
  localparam int OUT_USED = LEN_LO + blp_pkg::LEN_W;

  blp_pkg::cmd_t               cmd;
  blp_pkg::sts_t               sts;
  logic [blp_pkg::ELEM_W-1:0]  element;
  logic [blp_pkg::LEN_W-1:0]   length;

  // Sequencing: accept, readout stepping.
  blp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Cell row, count and output register.
  blp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (in_tuser),
    .in_value    (in_tdata[POS_LO-1:0]),
    .in_position (in_tdata[POS_LO+blp_pkg::POS_W-1:POS_LO]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_tuser),
    .out_element (element),
    .out_length  (length),
    .out_last    (out_tlast)
  );

  // Pack result fields, lowest first, pad to whole bytes.
  assign out_tdata = {{(blp_pkg::OUT_TDATA_W - OUT_USED){1'b0}}, length, element};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_positional_list_top: directed table then
// random ops, with results checked against a list predictor kept in this file.
// Depends on blp_pkg and the RTL of the block.
module tb_top;

  // Op code seven has no meaning; the block must flag it as an invalid index.
  localparam logic [blp_pkg::OP_W-1:0] OP_UNDEFINED = 3'd7;
  localparam int RANDOM_ITEMS = 372;
  localparam int CALM_ITEMS   = 60;     // tail of the run with no idling
  localparam int DRAIN_CYCLES = 20;

  // One result transaction as the predictor sees it.
  typedef struct packed {
    blp_pkg::status_t           status;
    logic [blp_pkg::ELEM_W-1:0] element;
    logic [blp_pkg::LEN_W-1:0]  length;
    logic                       is_last;
  } list_result_t;

  // One row of the directed table. A row with typed set carries its single
  // result inline; every other row is checked against the predictor.
  typedef struct {
    logic [blp_pkg::OP_W-1:0]    op;
    logic [blp_pkg::VALUE_W-1:0] value;
    logic [blp_pkg::POS_W-1:0]   pos;
    int                          reps;
    bit                          typed;
    blp_pkg::status_t            t_status;
    logic [blp_pkg::LEN_W-1:0]   t_length;
  } directed_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [blp_pkg::OP_W-1:0]        in_tuser = '0;
  logic [blp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [blp_pkg::STAT_W-1:0]      out_tuser;
  logic [blp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;

  // Predictor state: the list contents front first, and the results still owed.
  logic [blp_pkg::VALUE_W-1:0] list_cells[$];
  list_result_t                list_result_q[$];
  int                          fail_count = 0;
  bit                          calm = 1'b0;

  bounded_positional_list_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Apply one op to the list copy and queue every result it causes.
  function automatic void predict_list_op(input logic [blp_pkg::OP_W-1:0] op,
                                          input logic [blp_pkg::VALUE_W-1:0] value,
                                          input logic [blp_pkg::POS_W-1:0] pos);
    blp_pkg::status_t st;
    int               n;
    st = blp_pkg::STAT_OK;
    n = list_cells.size();
    case (op)
      blp_pkg::OP_PUSH_FRONT, blp_pkg::OP_PUSH_BACK, blp_pkg::OP_INS_AFTER: begin
        // full check comes before the position check
        if (n >= blp_pkg::CAPACITY) st = blp_pkg::STAT_FULL;
        else if (op == blp_pkg::OP_PUSH_FRONT) list_cells.push_front(value);
        else if (op == blp_pkg::OP_PUSH_BACK) list_cells.push_back(value);
        else if (int'(pos) >= n) st = blp_pkg::STAT_BADIDX;
        else list_cells.insert(int'(pos) + 1, value);
      end
      blp_pkg::OP_POP_FRONT, blp_pkg::OP_POP_BACK, blp_pkg::OP_DEL_AT: begin
        if (n == 0) st = blp_pkg::STAT_EMPTY;
        else if (op == blp_pkg::OP_POP_FRONT) void'(list_cells.pop_front());
        else if (op == blp_pkg::OP_POP_BACK) void'(list_cells.pop_back());
        else if (int'(pos) >= n) st = blp_pkg::STAT_BADIDX;
        else list_cells.delete(int'(pos));
      end
      blp_pkg::OP_READ: begin
        // an empty readout still answers once, flagged empty
        if (n == 0) begin
          list_result_q.push_back('{blp_pkg::STAT_EMPTY, '0, '0, 1'b1});
        end else begin
          for (int i = 0; i < n; i++)
            list_result_q.push_back('{blp_pkg::STAT_OK, list_cells[i],
                                      blp_pkg::LEN_W'(n), i == n - 1});
        end
        return;
      end
      default: st = blp_pkg::STAT_BADIDX;
    endcase
    list_result_q.push_back('{st, '0, blp_pkg::LEN_W'(list_cells.size()), 1'b1});
  endfunction

  // Drive one input transaction, hold it until accepted, then predict it.
  // A typed expectation replaces the predicted single result.
  task automatic issue_op(input logic [blp_pkg::OP_W-1:0] op,
                          input logic [blp_pkg::VALUE_W-1:0] value,
                          input logic [blp_pkg::POS_W-1:0] pos, input bit typed,
                          input blp_pkg::status_t t_status,
                          input logic [blp_pkg::LEN_W-1:0] t_length);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, pos, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_list_op(op, value, pos);
    if (typed) begin
      void'(list_result_q.pop_back());
      list_result_q.push_back('{t_status, '0, t_length, 1'b1});
    end
    // drop valid for a random burst now and then
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Sink side: ready for random stretches, stalled for random bursts.
  initial begin : sink_stall
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{blp_pkg::status_t'(out_tuser), out_tdata[31:0], out_tdata[36:32], out_tlast};
      if (list_result_q.size() == 0) begin
        $error("result with nothing expected: status %0d element %0h length %0d",
               got.status, got.element, got.length);
        fail_count++;
      end else begin
        want = list_result_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.element !== want.element) begin
          $error("element: expected %0h, actual %0h", want.element, got.element);
          fail_count++;
        end
        if (got.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, got.length);
          fail_count++;
        end
        if (got.is_last !== want.is_last) begin
          $error("last: expected %0b, actual %0b", want.is_last, got.is_last);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t               table_rows[$];
    int                          mode;
    int                          r;
    int                          n;
    logic [blp_pkg::OP_W-1:0]    op;
    logic [blp_pkg::VALUE_W-1:0] value;
    logic [blp_pkg::POS_W-1:0]   pos;

    // After reset: every delete, a readout and an insert after a position
    // on the empty list, then the extremes of value, the full list and
    // out-of-range positions.
    table_rows = '{
      '{blp_pkg::OP_READ,       32'h0,        4'd0,  1, 1, blp_pkg::STAT_EMPTY,  5'd0},
      '{blp_pkg::OP_POP_FRONT,  32'h0,        4'd0,  1, 1, blp_pkg::STAT_EMPTY,  5'd0},
      '{blp_pkg::OP_POP_BACK,   32'h0,        4'd0,  1, 1, blp_pkg::STAT_EMPTY,  5'd0},
      '{blp_pkg::OP_DEL_AT,     32'h0,        4'd0,  1, 1, blp_pkg::STAT_EMPTY,  5'd0},
      '{blp_pkg::OP_DEL_AT,     32'hFFFFFFFF, 4'd15, 1, 1, blp_pkg::STAT_EMPTY,  5'd0},
      '{blp_pkg::OP_INS_AFTER,  32'h5,        4'd0,  1, 1, blp_pkg::STAT_BADIDX, 5'd0},
      '{OP_UNDEFINED,           32'h0,        4'd0,  1, 1, blp_pkg::STAT_BADIDX, 5'd0},
      '{blp_pkg::OP_PUSH_BACK,  32'h7FFFFFFF, 4'd0,  1, 1, blp_pkg::STAT_OK,     5'd1},
      '{blp_pkg::OP_PUSH_FRONT, 32'h80000000, 4'd0,  1, 1, blp_pkg::STAT_OK,     5'd2},
      '{blp_pkg::OP_INS_AFTER,  32'hFFFFFFFF, 4'd1,  1, 1, blp_pkg::STAT_OK,     5'd3},
      '{blp_pkg::OP_INS_AFTER,  32'h1,        4'd3,  1, 1, blp_pkg::STAT_BADIDX, 5'd3},
      '{blp_pkg::OP_DEL_AT,     32'h0,        4'd3,  1, 1, blp_pkg::STAT_BADIDX, 5'd3},
      '{blp_pkg::OP_READ,       32'h0,        4'd0,  1, 0, blp_pkg::STAT_OK,     5'd0},
      '{blp_pkg::OP_INS_AFTER,  32'h0,        4'd0,  1, 1, blp_pkg::STAT_OK,     5'd4},
      '{blp_pkg::OP_PUSH_BACK,  32'h10000000, 4'd0, 12, 0, blp_pkg::STAT_OK,     5'd0},
      '{blp_pkg::OP_PUSH_FRONT, 32'h2,        4'd0,  1, 1, blp_pkg::STAT_FULL,   5'd16},
      '{blp_pkg::OP_INS_AFTER,  32'h3,        4'd15, 1, 1, blp_pkg::STAT_FULL,   5'd16},
      '{blp_pkg::OP_PUSH_BACK,  32'h4,        4'd0,  1, 1, blp_pkg::STAT_FULL,   5'd16},
      '{blp_pkg::OP_INS_AFTER,  32'h5,        4'd0,  1, 1, blp_pkg::STAT_FULL,   5'd16},
      '{blp_pkg::OP_READ,       32'h0,        4'd0,  1, 0, blp_pkg::STAT_OK,     5'd0},
      '{blp_pkg::OP_DEL_AT,     32'h0,        4'd15, 1, 1, blp_pkg::STAT_OK,     5'd15},
      '{blp_pkg::OP_DEL_AT,     32'h0,        4'd15, 1, 1, blp_pkg::STAT_BADIDX, 5'd15},
      '{blp_pkg::OP_DEL_AT,     32'h0,        4'd7,  1, 0, blp_pkg::STAT_OK,     5'd0},
      '{blp_pkg::OP_POP_FRONT,  32'h0,        4'd0,  1, 0, blp_pkg::STAT_OK,     5'd0},
      '{blp_pkg::OP_POP_BACK,   32'h0,        4'd0,  1, 0, blp_pkg::STAT_OK,     5'd0},
      '{OP_UNDEFINED,           32'hA5A5A5A5, 4'd9,  1, 1, blp_pkg::STAT_BADIDX, 5'd12},
      '{blp_pkg::OP_READ,       32'h0,        4'd0,  1, 0, blp_pkg::STAT_OK,     5'd0}
    };

    // Hold reset, then release it once.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; a repeated row steps its value per transaction.
    foreach (table_rows[k]) begin
      for (int j = 0; j < table_rows[k].reps; j++)
        issue_op(table_rows[k].op, table_rows[k].value + blp_pkg::VALUE_W'(j),
                 table_rows[k].pos, table_rows[k].typed, table_rows[k].t_status,
                 table_rows[k].t_length);
    end

    // Random ops in phases that grow, shrink or mix the list, so that both
    // the full and the empty list come up often.
    mode = 2;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 30 == 0) mode = $urandom_range(0, 2);
      if (k == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;

      // Hold the sender once until every owed result has drained.
      if (k == RANDOM_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (list_result_q.size() != 0) @(posedge clk);
      end

      r = $urandom_range(0, 99);
      case (mode)
        0: op = (r < 25) ? blp_pkg::OP_PUSH_FRONT : (r < 50) ? blp_pkg::OP_PUSH_BACK :
                (r < 70) ? blp_pkg::OP_INS_AFTER  : (r < 78) ? blp_pkg::OP_POP_FRONT :
                (r < 84) ? blp_pkg::OP_POP_BACK   : (r < 90) ? blp_pkg::OP_DEL_AT    :
                (r < 97) ? blp_pkg::OP_READ       : OP_UNDEFINED;
        1: op = (r < 8)  ? blp_pkg::OP_PUSH_FRONT : (r < 16) ? blp_pkg::OP_PUSH_BACK :
                (r < 24) ? blp_pkg::OP_INS_AFTER  : (r < 44) ? blp_pkg::OP_POP_FRONT :
                (r < 64) ? blp_pkg::OP_POP_BACK   : (r < 84) ? blp_pkg::OP_DEL_AT    :
                (r < 95) ? blp_pkg::OP_READ       : OP_UNDEFINED;
        default: op = blp_pkg::OP_W'($urandom_range(0, 7));
      endcase

      // Mostly full-range words, with the sign extremes mixed in.
      case ($urandom_range(0, 9))
        0: value = 32'h80000000;
        1: value = 32'h7FFFFFFF;
        2: value = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFFFFFF;
        default: value = $urandom;
      endcase

      // Mostly valid positions, sometimes any position.
      n = list_cells.size();
      if (n > 0 && $urandom_range(0, 3) != 0) pos = blp_pkg::POS_W'($urandom_range(0, n - 1));
      else pos = blp_pkg::POS_W'($urandom_range(0, 15));

      issue_op(op, value, pos, 1'b0, blp_pkg::STAT_OK, '0);
    end

    // Drain: wait until nothing is owed, then watch for stray results.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (list_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/blp_pkg.sv
rtl/core/blp_ctrl.sv
rtl/core/blp_dp.sv
rtl/core/bounded_positional_list_top.sv
test/tb_top.sv
